>>> rtl/mtg_pkg.sv
package mtg_pkg;

	localparam int WORD_W       = 32;
	localparam int STATE_WORDS  = 624;
	localparam int SHIFT_OFFSET = 397;
	localparam int IDX_W        = $clog2(STATE_WORDS);

	localparam logic [WORD_W-1:0] MT_MATRIX   = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] MT_INIT_MUL = 32'h6c07_8965;
	localparam logic [WORD_W-1:0] MT_TEMPER_B = 32'h9d2c_5680;
	localparam logic [WORD_W-1:0] MT_TEMPER_C = 32'hefc6_0000;
	localparam logic [WORD_W-1:0] MT_UPPER    = 32'h8000_0000;
	localparam logic [WORD_W-1:0] MT_LOWER    = 32'h7fff_ffff;

	typedef enum logic {
		ACT_NEXT = 1'b0,
		ACT_SEED = 1'b1
	} action_t;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// Output tempering: four shift and mask steps, all combinational
	function automatic word_t temper(input word_t x);
		word_t y;
		y = x;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & MT_TEMPER_B);
		y = y ^ ((y << 15) & MT_TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

>>> rtl/mtg_if.sv
interface mtg_cmd_if
	import mtg_pkg::*;
;
	logic        valid;
	logic        ready;
	logic        action;
	word_t       seed_value;

	modport source (output valid, output action, output seed_value, input ready);
	modport sink   (input valid, input action, input seed_value, output ready);
endinterface

interface mtg_rnd_if
	import mtg_pkg::*;
;
	logic        valid;
	logic        ready;
	word_t       random_word;

	modport source (output valid, output random_word, input ready);
	modport sink   (input valid, input random_word, output ready);
endinterface

>>> rtl/mersenne_twister_generator.sv
// MT19937 generator, 32-bit words. The 624-word state sits in one on-chip memory with two
// registered read ports and one write port. A seed transfer (action = 1) rebuilds the state
// with the standard initialisation recurrence and gives no result; it keeps the block busy
// while every further word takes the 32x32 multiply and then the add that follows it.
// A next transfer (action = 0) gives one tempered word. While the read index is not zero this
// takes one memory read and one tempering step into the output register. When
// the index is zero the whole state is first twisted in place, one word at a time
// (read the neighbour and the far word, then compute and write back), which delays
// that item, once every 624 words. The output register holds a finished word
// while the command side carries on; a next item that finds it still full waits. The first
// transfer after reset must be a seed: the state memory is not cleared.
module mersenne_twister_generator
	import mtg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	mtg_cmd_if.sink   cmd,
	mtg_rnd_if.source rnd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_ADD,
		ST_TW_LOAD,
		ST_TW_RD,
		ST_TW_CALC,
		ST_OUT
	} state_t;

	localparam idx_t LAST_IDX  = IDX_W'(STATE_WORDS - 1);
	localparam idx_t FAR_UP    = IDX_W'(SHIFT_OFFSET);
	localparam idx_t FAR_DOWN  = IDX_W'(STATE_WORDS - SHIFT_OFFSET);

	state_t state_q;
	idx_t   idx_q;       // word under work in seeding or twisting
	idx_t   pos_q;       // read position
	word_t  prev_q;      // last seeded word
	word_t  prod_s1;     // seeding multiply result
	word_t  cur_q;       // old value of the word being twisted
	word_t  new0_q;      // twisted word zero, needed by the last word
	word_t  out_word_q;
	logic   out_valid_q;

	// State memory
	word_t  mem [STATE_WORDS];
	word_t  rdata_a_q;
	word_t  rdata_b_q;
	idx_t   raddr_a;
	idx_t   raddr_b;
	logic   wen;
	idx_t   waddr;
	word_t  wdata;

	logic   cmd_xfer;
	logic   out_free;
	idx_t   idx_inc;
	idx_t   far_idx;
	word_t  lower_src;
	word_t  twist_y;
	word_t  twist_word;
	word_t  seed_word;

	assign cmd.ready   = (state_q == ST_IDLE);
	assign cmd_xfer    = cmd.valid && cmd.ready;
	assign rnd.valid   = out_valid_q;
	assign rnd.random_word = out_word_q;
	assign out_free    = !out_valid_q || rnd.ready;

	// wrap past the last word so the neighbour read stays inside the memory
	assign idx_inc = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign far_idx = (idx_q < FAR_DOWN) ? idx_q + FAR_UP : idx_q - FAR_DOWN;

	// Twist step: the last word pairs with the already twisted word zero
	assign lower_src  = (idx_q == LAST_IDX) ? new0_q : rdata_a_q;
	assign twist_y    = (cur_q & MT_UPPER) | (lower_src & MT_LOWER);
	assign twist_word = rdata_b_q ^ (twist_y >> 1) ^ (twist_y[0] ? MT_MATRIX : '0);

	assign seed_word  = prod_s1 + WORD_W'(idx_q);

	// Memory port control
	always_comb begin
		raddr_a = pos_q;
		raddr_b = far_idx;
		wen     = 1'b0;
		waddr   = idx_q;
		wdata   = twist_word;
		unique case (state_q)
			ST_IDLE: begin
				// seed word zero goes straight in
				wen   = cmd_xfer && (cmd.action == ACT_SEED);
				waddr = '0;
				wdata = cmd.seed_value;
			end
			ST_SEED_ADD: begin
				wen   = 1'b1;
				wdata = seed_word;
			end
			ST_TW_LOAD, ST_TW_RD: begin
				raddr_a = idx_inc;
			end
			ST_TW_CALC: begin
				wen = 1'b1;
			end
			ST_SEED_MUL, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			pos_q       <= '0;
			prev_q      <= '0;
			prod_s1     <= '0;
			cur_q       <= '0;
			new0_q      <= '0;
			out_word_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a finished word, or drop the held one once it is taken
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rnd.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_xfer) begin
						if (cmd.action == ACT_SEED) begin
							prev_q  <= cmd.seed_value;
							idx_q   <= IDX_W'(1);
							pos_q   <= '0;
							state_q <= ST_SEED_MUL;
						end else if (pos_q == '0) begin
							idx_q   <= '0;
							state_q <= ST_TW_LOAD;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_SEED_MUL: begin
					prod_s1 <= (prev_q ^ (prev_q >> 30)) * MT_INIT_MUL;
					state_q <= ST_SEED_ADD;
				end
				ST_SEED_ADD: begin
					prev_q <= seed_word;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_inc;
						state_q <= ST_SEED_MUL;
					end
				end
				ST_TW_LOAD: begin
					// word zero, read on the transfer cycle
					cur_q   <= rdata_a_q;
					state_q <= ST_TW_CALC;
				end
				ST_TW_RD: begin
					state_q <= ST_TW_CALC;
				end
				ST_TW_CALC: begin
					cur_q <= rdata_a_q;
					if (idx_q == '0) begin
						new0_q <= twist_word;
					end
					if (idx_q == LAST_IDX) begin
						state_q <= ST_OUT;
					end else begin
						idx_q   <= idx_inc;
						state_q <= ST_TW_RD;
					end
				end
				ST_OUT: begin
					// hold until the output register is free
					if (out_free) begin
						out_word_q  <= temper(rdata_a_q);
						pos_q       <= (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_IDX)
		else $error("read position out of range");

	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("output word loaded outside the read step");

	a_twist_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TW_CALC && idx_q == LAST_IDX) |=> (state_q == ST_OUT && pos_q == '0))
		else $error("twist did not end in a read of word zero");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(wen && state_q != ST_IDLE) |-> (state_q == ST_SEED_ADD || state_q == ST_TW_CALC))
		else $error("state memory written outside seeding or twisting");

endmodule

>>> tb/tb_top.sv
module tb_top;
	import mtg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Give up once this many cycles pass with no transfer on either channel. A seed
	// keeps the block busy and the first word after it waits for a full twist of the
	// state; the long hold-off on the result side adds to that wait.
	localparam int STALL_LIMIT   = 10000;
	localparam int DRAIN_CYCLES  = 50;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AT_WORD  = 60;
	localparam int QUIET_TAIL    = 150;
	localparam int TARGET_ITEMS  = 1350;

	typedef struct packed {
		action_t act;
		word_t   seed;
	} mt_cmd_t;

	logic clk;
	logic arst_n;

	mtg_cmd_if cmd_bus ();
	mtg_rnd_if rnd_bus ();

	mersenne_twister_generator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus.sink),
		.rnd    (rnd_bus.source)
	);

	// Commands waiting to be offered, and words the generator still owes us
	mt_cmd_t cmd_backlog [$];
	word_t   owed_words  [$];

	// Our own copy of the generator state
	word_t       mt_words [STATE_WORDS];
	int unsigned mt_pos;

	int n_cmds;
	int n_words;
	int n_bad;
	int idle_cycles;
	int send_gap;
	int sink_gap;
	int hold_left;
	bit held_once;

	// Standard tempering, written as separate shift-and-mask stages
	function automatic word_t mt_shape(input word_t raw);
		word_t a;
		word_t b;
		word_t c;
		a = raw ^ {11'b0, raw[WORD_W-1:11]};
		b = a ^ ({a[WORD_W-8:0], 7'b0} & MT_TEMPER_B);
		c = b ^ ({b[WORD_W-16:0], 15'b0} & MT_TEMPER_C);
		return c ^ {18'b0, c[WORD_W-1:18]};
	endfunction

	// Fill the state from a seed word with the multiplier recurrence
	function automatic void mt_load(input word_t seed);
		word_t prev;
		mt_words[0] = seed;
		for (int i = 1; i < STATE_WORDS; i++) begin
			prev        = mt_words[i-1];
			mt_words[i] = (prev ^ (prev >> 30)) * MT_INIT_MUL + word_t'(i);
		end
		mt_pos = 0;
	endfunction

	// Regenerate the whole state in place
	function automatic void mt_regen();
		word_t       y;
		int unsigned nxt;
		int unsigned far;
		for (int unsigned i = 0; i < STATE_WORDS; i++) begin
			nxt         = (i + 1) % STATE_WORDS;
			far         = (i + SHIFT_OFFSET) % STATE_WORDS;
			y           = (mt_words[i] & MT_UPPER) | (mt_words[nxt] & MT_LOWER);
			mt_words[i] = mt_words[far] ^ (y >> 1) ^ (y[0] ? MT_MATRIX : '0);
		end
	endfunction

	// Apply one accepted command to our state; a next command owes one word
	function automatic void mt_advance(input mt_cmd_t c);
		if (c.act == ACT_SEED) begin
			mt_load(c.seed);
		end else begin
			if (mt_pos == 0)
				mt_regen();
			owed_words.push_back(mt_shape(mt_words[mt_pos]));
			mt_pos = (mt_pos == STATE_WORDS - 1) ? 0 : mt_pos + 1;
		end
	endfunction

	function automatic void queue_seed(input word_t s);
		mt_cmd_t c;
		c.act  = ACT_SEED;
		c.seed = s;
		cmd_backlog.push_back(c);
	endfunction

	// The seed field is ignored on a next command; fill it with noise anyway
	function automatic void queue_next(input int count);
		mt_cmd_t c;
		for (int k = 0; k < count; k++) begin
			c.act  = ACT_NEXT;
			c.seed = $urandom;
			cmd_backlog.push_back(c);
		end
	endfunction

	function automatic word_t pick_seed();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return MT_UPPER;
			default: return $urandom;
		endcase
	endfunction

	// Clock, and a reset pulse at the start
	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		cmd_bus.valid      = 1'b0;
		cmd_bus.action     = ACT_NEXT;
		cmd_bus.seed_value = '0;
		rnd_bus.ready      = 1'b0;
		fork
			forever #5 clk = ~clk;
			begin
				repeat (7) @(posedge clk);
				arst_n <= 1'b1;
			end
		join
	end

	// Stimulus, then the drain and the verdict
	initial begin
		mt_cmd_t c;

		// Directed: extreme seeds, the usual default seed, back-to-back seeds,
		// and a next command carrying an all-ones seed field that must be ignored
		queue_seed('0);
		queue_next(2);
		queue_seed('1);
		c.act  = ACT_NEXT;
		c.seed = '1;
		cmd_backlog.push_back(c);
		queue_next(1);
		queue_seed(32'd5489);
		queue_next(3);
		queue_seed(MT_UPPER);
		queue_next(1);
		queue_seed(32'h0000_0001);
		queue_seed(MT_LOWER);
		queue_next(2);
		queue_seed(32'h1234_5678);
		queue_next(1);

		// One long run that passes the wrap of the read position, so the second
		// regeneration works on an already regenerated state
		queue_seed($urandom);
		queue_next($urandom_range(630, 720));

		// Then short runs ending at random positions; some seeds come back to back
		while (cmd_backlog.size() < TARGET_ITEMS) begin
			queue_seed(pick_seed());
			if ($urandom_range(0, 7) != 0)
				queue_next($urandom_range(1, 40));
		end

		// Wait for every command to be taken and every owed word to arrive
		while (cmd_backlog.size() != 0 || cmd_bus.valid)
			@(posedge clk);
		while (owed_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_bad == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Command driver: take the transfer, then load the next command or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_bus.valid      <= 1'b0;
			cmd_bus.action     <= ACT_NEXT;
			cmd_bus.seed_value <= '0;
			send_gap           <= 0;
			n_cmds             = 0;
		end else begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				mt_advance(mt_cmd_t'{action_t'(cmd_bus.action), cmd_bus.seed_value});
				n_cmds++;
			end
			// Only touch the bus when the slot is free
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (send_gap > 0) begin
					send_gap      <= send_gap - 1;
					cmd_bus.valid <= 1'b0;
				end else if (cmd_backlog.size() != 0) begin
					c_load: begin
						mt_cmd_t nc;
						nc                 = cmd_backlog.pop_front();
						cmd_bus.valid      <= 1'b1;
						cmd_bus.action     <= nc.act;
						cmd_bus.seed_value <= nc.seed;
					end
					// Idle in bursts, but leave every third stretch and the tail clean
					if (cmd_backlog.size() > QUIET_TAIL && (n_cmds / 128) % 3 != 2
							&& $urandom_range(0, 5) == 0)
						send_gap <= $urandom_range(1, 5);
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each transfer against the oldest owed word, and
	// drive ready with random bursts plus one long hold-off that backs the
	// generator up until it stops taking commands
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_bus.ready <= 1'b0;
			sink_gap      <= 0;
			hold_left     <= 0;
			held_once     <= 1'b0;
			n_words       = 0;
			n_bad         = 0;
		end else begin
			if (rnd_bus.valid && rnd_bus.ready) begin
				if (owed_words.size() == 0) begin
					$display("%0t: unexpected random word, expected none, got %08h",
						$time, rnd_bus.random_word);
					n_bad++;
				end else begin
					chk: begin
						word_t want;
						want = owed_words.pop_front();
						if (rnd_bus.random_word !== want) begin
							$display("%0t: random_word mismatch, expected %08h, got %08h",
								$time, want, rnd_bus.random_word);
							n_bad++;
						end
					end
				end
				n_words++;
			end

			if (hold_left > 0) begin
				hold_left     <= hold_left - 1;
				rnd_bus.ready <= 1'b0;
			end else if (!held_once && n_words == HOLD_AT_WORD) begin
				held_once     <= 1'b1;
				hold_left     <= HOLD_CYCLES - 1;
				rnd_bus.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap      <= sink_gap - 1;
				rnd_bus.ready <= 1'b0;
			end else if (cmd_backlog.size() > QUIET_TAIL && (n_words / 100) % 3 != 1
					&& $urandom_range(0, 5) == 0) begin
				sink_gap      <= $urandom_range(0, 4);
				rnd_bus.ready <= 1'b0;
			end else begin
				rnd_bus.ready <= 1'b1;
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves anything
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((cmd_bus.valid && cmd_bus.ready) || (rnd_bus.valid && rnd_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

>>> sim.f
rtl/mtg_pkg.sv
rtl/mtg_if.sv
rtl/mersenne_twister_generator.sv
tb/tb_top.sv
